// ===== rtl/rar_pkg.sv =====
package rar_pkg;

    localparam int OperandWidth = 16;
    localparam int NumWidth     = 2 * OperandWidth + 1;
    localparam int DenWidth     = 2 * OperandWidth;
    // width of magnitudes handled by the divider
    localparam int MagWidth     = NumWidth;
    localparam int CntWidth     = $clog2(MagWidth + 1);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    // divider target select
    localparam logic [1:0] DSEL_GCD = 2'd0;
    localparam logic [1:0] DSEL_NUM = 2'd1;
    localparam logic [1:0] DSEL_DEN = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_step;
        logic       raw_step;
        logic       gcd_init;
        logic       div_start;
        logic [1:0] div_sel;
        logic       gcd_swap;
        logic       quot_store;
        logic       out_load;
        logic       out_err;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic den_zero;
        logic rem_zero;
    } t_stat;

endpackage

// ===== rtl/rar_if.sv =====
interface rar_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic signed [rar_pkg::OperandWidth-1:0] num_a;
    logic signed [rar_pkg::OperandWidth-1:0] den_a;
    logic signed [rar_pkg::OperandWidth-1:0] num_b;
    logic signed [rar_pkg::OperandWidth-1:0] den_b;
    modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
    modport sink (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rar_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rar_pkg::NumWidth-1:0] res_num;
    logic signed [rar_pkg::DenWidth-1:0] res_den;
    logic                                error;
    modport source (output valid, res_num, res_den, error, input ready);
    modport sink (input valid, res_num, res_den, error, output ready);
endinterface

// ===== rtl/rar_ctrl.sv =====
module rar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rar_pkg::t_stat i_stat,
    output rar_pkg::t_cmd  o_cmd
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_RAW   = 4'd2;
    localparam logic [3:0] S_GCHK  = 4'd3;
    localparam logic [3:0] S_GDIV  = 4'd4;
    localparam logic [3:0] S_GWAIT = 4'd5;
    localparam logic [3:0] S_NDIV  = 4'd6;
    localparam logic [3:0] S_NWAIT = 4'd7;
    localparam logic [3:0] S_DDIV  = 4'd8;
    localparam logic [3:0] S_DWAIT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // sequencing of one request
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_RAW;
            end
            S_RAW: begin
                o_cmd.raw_step = 1'b1;
                n_state        = S_GCHK;
            end
            S_GCHK: begin
                if (i_stat.den_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GDIV;
                end
            end
            S_GDIV: begin
                if (i_stat.rem_zero) begin
                    n_state = S_NDIV;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_GCD;
                    n_state         = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.gcd_swap = 1'b1;
                    n_state        = S_GDIV;
                end
            end
            S_NDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_NUM;
                n_state         = S_NWAIT;
            end
            S_NWAIT: begin
                o_cmd.div_sel = DSEL_NUM;
                if (!i_stat.div_busy) begin
                    o_cmd.quot_store = 1'b1;
                    n_state          = S_DDIV;
                end
            end
            S_DDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_DEN;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                o_cmd.div_sel = DSEL_DEN;
                if (!i_stat.div_busy) begin
                    o_cmd.quot_store = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/rar_dp.sv =====
module rar_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rar_pkg::t_cmd                     i_cmd,
    output rar_pkg::t_stat                    o_stat,
    input  logic [1:0]                        i_command,
    input  logic signed [rar_pkg::OperandWidth-1:0] i_num_a,
    input  logic signed [rar_pkg::OperandWidth-1:0] i_den_a,
    input  logic signed [rar_pkg::OperandWidth-1:0] i_num_b,
    input  logic signed [rar_pkg::OperandWidth-1:0] i_den_b,
    output logic signed [rar_pkg::NumWidth-1:0] o_res_num,
    output logic signed [rar_pkg::DenWidth-1:0] o_res_den,
    output logic                              o_error
);
    import rar_pkg::*;

    localparam int PW = 2 * OperandWidth;

    logic [1:0]                     r_cmd;
    logic signed [OperandWidth-1:0] r_na, r_da, r_nb, r_db;
    logic signed [PW-1:0]           r_p0, r_p1, r_pd;
    logic signed [NumWidth-1:0]     r_n;
    logic signed [DenWidth-1:0]     r_d;
    // euclid operands, x and y
    logic signed [NumWidth-1:0]     r_x, r_y;
    logic signed [NumWidth-1:0]     r_qn;
    logic signed [DenWidth-1:0]     r_qd;
    // shift-subtract divider on magnitudes
    logic [MagWidth-1:0]            r_rem, r_quo, r_dvs;
    logic [CntWidth-1:0]            r_cnt;
    logic                           r_busy, r_qneg, r_rneg;
    logic signed [NumWidth-1:0]     r_onum;
    logic signed [DenWidth-1:0]     r_oden;
    logic                           r_oerr;

    logic signed [NumWidth-1:0] w_dvd, w_dsr;
    logic [MagWidth-1:0]        w_rem_sh, w_trial;
    logic                       w_ge;

    // operand capture and products, one multiplier per product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_na <= i_num_a; r_da <= i_den_a; r_nb <= i_num_b; r_db <= i_den_b;
        end
        if (i_cmd.mul_step) begin
            r_p0 <= PW'(r_na) * PW'(r_cmd == CMD_MUL ? r_nb : r_db);
            r_p1 <= PW'(r_da) * PW'(r_nb);
            r_pd <= PW'(r_cmd == CMD_DIV ? r_nb : r_db) * PW'(r_da);
        end
        if (i_cmd.raw_step) begin
            case (r_cmd)
                CMD_ADD: r_n <= NumWidth'(r_p0) + NumWidth'(r_p1);
                CMD_SUB: r_n <= NumWidth'(r_p0) - NumWidth'(r_p1);
                default: r_n <= NumWidth'(r_p0);
            endcase
            r_d <= r_pd;
        end
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            DSEL_NUM: begin w_dvd = r_n;             w_dsr = r_x; end
            DSEL_DEN: begin w_dvd = NumWidth'(r_d);  w_dsr = r_x; end
            default:  begin w_dvd = r_x;             w_dsr = r_y; end
        endcase
    end

    assign w_rem_sh = {r_rem[MagWidth-2:0], r_quo[MagWidth-1]};
    assign w_ge     = w_rem_sh >= r_dvs;
    assign w_trial  = w_rem_sh - r_dvs;

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CntWidth'(MagWidth);
            r_rem  <= '0;
            r_quo  <= w_dvd[NumWidth-1] ? MagWidth'(-w_dvd) : MagWidth'(w_dvd);
            r_dvs  <= w_dsr[NumWidth-1] ? MagWidth'(-w_dsr) : MagWidth'(w_dsr);
            r_qneg <= w_dvd[NumWidth-1] ^ w_dsr[NumWidth-1];
            r_rneg <= w_dvd[NumWidth-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial : w_rem_sh;
            r_quo <= {r_quo[MagWidth-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntWidth'(1)) r_busy <= 1'b0;
        end
    end

    // euclid registers and quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_x <= r_n;
            r_y <= NumWidth'(r_d);
        end
        if (i_cmd.gcd_swap) begin
            r_x <= r_y;
            r_y <= r_rneg ? -$signed(r_rem) : $signed(r_rem);
        end
        if (i_cmd.quot_store) begin
            if (i_cmd.div_sel == DSEL_NUM)
                r_qn <= r_qneg ? -$signed(r_quo) : $signed(r_quo);
            else
                r_qd <= DenWidth'(r_qneg ? -$signed(r_quo) : $signed(r_quo));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_onum <= i_cmd.out_err ? '0 : r_qn;
            r_oden <= i_cmd.out_err ? '0 : r_qd;
            r_oerr <= i_cmd.out_err;
        end
    end

    assign o_stat.div_busy = r_busy;
    assign o_stat.den_zero = (r_d == '0);
    assign o_stat.rem_zero = (r_y == '0);
    assign o_res_num = r_onum;
    assign o_res_den = r_oden;
    assign o_error   = r_oerr;
endmodule

// ===== rtl/rational_arith_reduce_core.sv =====
// sequence: capture, multiply, raw result, then euclid passes on the divider
// and one divider pass each to reduce numerator and denominator; when the
// raw denominator is zero the divider is skipped and an error result is given
// throughput: one request at a time, set by the shared bit-serial divider
// reset: synchronous active-low i_rst_n returns the controller to idle and
// stops the divider; payload registers are not reset
module rational_arith_reduce_core (
    input logic i_clk,
    input logic i_rst_n,
    rar_in_if.sink    i_in,
    rar_out_if.source o_out
);
    import rar_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rar_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_command (i_in.command),
        .i_num_a   (i_in.num_a),
        .i_den_a   (i_in.den_a),
        .i_num_b   (i_in.num_b),
        .i_den_b   (i_in.den_b),
        .o_res_num (o_out.res_num),
        .o_res_den (o_out.res_den),
        .o_error   (o_out.error)
    );
endmodule
